@@ sv/fpba_pkg.sv @@
// Shared types and codes for the fit-policy block allocator.
`default_nettype none

package fpba_pkg;

    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int STATUS_W     = 2;
    localparam int POLICY_W     = 2;
    localparam int NBLK_W       = 5;
    localparam int CFG_DATA_W   = 5;

    localparam logic [0:0] REG_FIT_POLICY = 1'b0;
    localparam logic [0:0] REG_NUM_BLOCKS = 1'b1;

    localparam logic [0:0] REQ_LOAD     = 1'b0;
    localparam logic [0:0] REQ_ALLOCATE = 1'b1;

    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

    localparam logic [POLICY_W-1:0] FIT_POLICY_RESET = FIT_FIRST;
    localparam logic [NBLK_W-1:0]   NUM_BLOCKS_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

endpackage

`default_nettype wire

@@ sv/fit_policy_block_allocator_core.sv @@
// Fit-policy block allocator: free-size table with first, best and worst fit search.
// A load item, or an allocate item with no blocks in use, gives its result at the edge
// that accepts it. Otherwise an allocate item is accepted, then scans count entries,
// count = min(num_blocks, NUM_BLOCKS), through the table's single read port (registered
// read data), then writes back and responds once the output is free. Reset clears the
// table through per-entry valid bits, sets fit_policy to first fit and num_blocks to 16;
// the block is ready right after reset.
`default_nettype none

module fit_policy_block_allocator_core #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_WIDTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [3:0] block_index, [19:4] size_value, [23:20] zero
    input  wire logic [0:0]  s_tuser,   // [0] req_type

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] chosen_block, [19:4] remaining_size, [23:20] zero
    output logic [1:0]       m_tuser    // [1:0] status
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    fpba_pkg::state_t state_reg, state_next;

    logic [fpba_pkg::POLICY_W-1:0] policy_reg;
    logic [fpba_pkg::NBLK_W-1:0]   nblk_reg;

    logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg, valid_next;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [SIZE_WIDTH-1:0] mem_wd;
    logic [IDX_W-1:0]      mem_ra;

    logic [SIZE_WIDTH-1:0] rd_data_reg;
    logic                  rd_bit_reg;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_idx_reg;

    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic [SIZE_WIDTH-1:0] best_reg, best_next;
    logic [SIZE_WIDTH-1:0] req_reg, req_next;

    logic                  out_vld_reg, out_vld_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [3:0]            out_block_reg, out_block_next;
    logic [15:0]           out_size_reg, out_size_next;

    logic                  out_free;
    logic                  in_fire;
    logic [3:0]            in_idx;
    logic [SIZE_WIDTH-1:0] in_size;
    logic [CNT_W-1:0]      in_count;
    logic [SIZE_WIDTH-1:0] have;
    logic                  take;
    logic [SIZE_WIDTH-1:0] diff;

    assign out_free = !out_vld_reg || m_tready;
    assign s_tready = (state_reg == fpba_pkg::ST_IDLE) && out_free;
    assign in_fire  = s_tvalid && s_tready;
    assign in_idx   = s_tdata[3:0];
    assign in_size  = SIZE_WIDTH'(s_tdata[19:4]);
    assign in_count = (nblk_reg > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : CNT_W'(nblk_reg);
    assign have     = rd_bit_reg ? rd_data_reg : '0;
    assign diff     = best_reg - req_reg;
    assign mem_ra   = issue_reg[IDX_W-1:0];

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'd0, out_size_reg, out_block_reg};

    always_comb
    begin
        take = 1'b0;
        if (rd_vld_reg && have >= req_reg)
        begin
            if (!found_reg)
                take = 1'b1;
            else if (policy_reg == fpba_pkg::FIT_BEST)
                take = have < best_reg;
            else if (policy_reg == fpba_pkg::FIT_WORST)
                take = have > best_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        issue_next      = issue_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        req_next        = req_reg;
        rd_vld_next     = 1'b0;
        out_vld_next    = out_vld_reg && !m_tready;
        out_status_next = out_status_reg;
        out_block_next  = out_block_reg;
        out_size_next   = out_size_reg;
        mem_we          = 1'b0;
        mem_wa          = IDX_W'(in_idx);
        mem_wd          = in_size;

        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_tuser[0] == fpba_pkg::REQ_LOAD)
                    begin
                        out_vld_next    = 1'b1;
                        out_status_next = fpba_pkg::STATUS_LOADED;
                        out_block_next  = in_idx;
                        out_size_next   = '0;
                        if (in_idx < NUM_BLOCKS)
                        begin
                            mem_we                = 1'b1;
                            valid_next[mem_wa]    = 1'b1;
                            out_size_next         = 16'(in_size);
                        end
                    end
                    else
                    begin
                        req_next   = in_size;
                        count_next = in_count;
                        issue_next = '0;
                        found_next = 1'b0;
                        if (in_count == '0)
                        begin
                            out_vld_next    = 1'b1;
                            out_status_next = fpba_pkg::STATUS_NO_FIT;
                            out_block_next  = '0;
                            out_size_next   = '0;
                        end
                        else
                        begin
                            state_next = fpba_pkg::ST_SCAN;
                        end
                    end
                end
            end

            fpba_pkg::ST_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                if (take)
                begin
                    found_next = 1'b1;
                    pick_next  = rd_idx_reg;
                    best_next  = have;
                end
                if (issue_reg == count_reg && rd_vld_reg)
                    state_next = fpba_pkg::ST_UPDATE;
            end

            fpba_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    state_next   = fpba_pkg::ST_IDLE;
                    if (found_reg)
                    begin
                        mem_we               = 1'b1;
                        mem_wa               = pick_reg;
                        mem_wd               = diff;
                        valid_next[pick_reg] = 1'b1;
                        out_status_next      = fpba_pkg::STATUS_ALLOCATED;
                        out_block_next       = 4'(pick_reg);
                        out_size_next        = 16'(diff);
                    end
                    else
                    begin
                        out_status_next = fpba_pkg::STATUS_NO_FIT;
                        out_block_next  = '0;
                        out_size_next   = '0;
                    end
                end
            end

            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fpba_pkg::ST_IDLE;
            policy_reg  <= fpba_pkg::FIT_POLICY_RESET;
            nblk_reg    <= fpba_pkg::NUM_BLOCKS_RESET;
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            issue_reg   <= '0;
            count_reg   <= '0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rd_vld_reg  <= rd_vld_next;
            issue_reg   <= issue_next;
            count_reg   <= count_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fpba_pkg::REG_FIT_POLICY: policy_reg <= cfg_data[fpba_pkg::POLICY_W-1:0];
                    fpba_pkg::REG_NUM_BLOCKS: nblk_reg   <= cfg_data[fpba_pkg::NBLK_W-1:0];
                    default:                  policy_reg <= policy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        req_reg        <= req_next;
        out_status_reg <= out_status_next;
        out_block_reg  <= out_block_next;
        out_size_reg   <= out_size_next;
        rd_idx_reg     <= mem_ra;
        rd_bit_reg     <= valid_reg[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_reg <= count_reg)
        else $error("scan issued past the block count");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == fpba_pkg::ST_SCAN) || m_tvalid)
        else $error("accepted item neither scanned nor answered");

    a_update_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_UPDATE && out_free) |=>
            m_tvalid && (m_tuser == fpba_pkg::STATUS_ALLOCATED
                         || m_tuser == fpba_pkg::STATUS_NO_FIT))
        else $error("update step gave no allocation result");

    a_found_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_UPDATE && found_reg) |-> best_reg >= req_reg)
        else $error("chosen block smaller than request");

    a_scan_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpba_pkg::ST_SCAN) |-> !s_tready)
        else $error("ready during scan");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the fit-policy block allocator under all fit policies.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int SIZE_BITS   = 16;
    localparam int LIMIT       = 400000;

    typedef struct packed {
        logic [fpba_pkg::STATUS_W-1:0]     status;
        logic [fpba_pkg::IDX_FIELD_W-1:0]  block;
        logic [fpba_pkg::SIZE_FIELD_W-1:0] left;
    } reply_t;

    class allocation_ledger;
        logic [fpba_pkg::SIZE_FIELD_W-1:0] free_size [TABLE_DEPTH];
        logic [fpba_pkg::POLICY_W-1:0]     policy;
        logic [fpba_pkg::NBLK_W-1:0]       blocks_used;
        reply_t                            due [$];
        int                                errors;
        int                                loads;
        int                                grants;
        int                                refusals;

        function new();
            foreach (free_size[k])
                free_size[k] = '0;
            policy      = fpba_pkg::FIT_POLICY_RESET;
            blocks_used = fpba_pkg::NUM_BLOCKS_RESET;
            errors      = 0;
            loads       = 0;
            grants      = 0;
            refusals    = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [fpba_pkg::CFG_DATA_W-1:0] value);
            if (idx == fpba_pkg::REG_FIT_POLICY)
                policy = value[fpba_pkg::POLICY_W-1:0];
            else
                blocks_used = value[fpba_pkg::NBLK_W-1:0];
        endfunction

        function void note_request(logic [0:0] kind, logic [fpba_pkg::IDX_FIELD_W-1:0] idx,
                                   logic [fpba_pkg::SIZE_FIELD_W-1:0] amount);
            reply_t r;
            int     scan;
            bit     found;
            int     pick;
            if (kind == fpba_pkg::REQ_LOAD)
            begin
                free_size[idx] = amount;
                r = '{fpba_pkg::STATUS_LOADED, idx, amount};
                loads++;
            end
            else
            begin
                scan  = (int'(blocks_used) > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_used);
                found = 1'b0;
                pick  = 0;
                for (int j = 0; j < scan; j++)
                begin
                    if (free_size[j] < amount)
                        continue;
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = j;
                        if (policy != fpba_pkg::FIT_BEST && policy != fpba_pkg::FIT_WORST)
                            break;
                    end
                    else if (policy == fpba_pkg::FIT_BEST && free_size[j] < free_size[pick])
                        pick = j;
                    else if (policy == fpba_pkg::FIT_WORST && free_size[j] > free_size[pick])
                        pick = j;
                end
                if (!found)
                begin
                    r = '{fpba_pkg::STATUS_NO_FIT, '0, '0};
                    refusals++;
                end
                else
                begin
                    free_size[pick] = free_size[pick] - amount;
                    r = '{fpba_pkg::STATUS_ALLOCATED, fpba_pkg::IDX_FIELD_W'(pick),
                          free_size[pick]};
                    grants++;
                end
            end
            due.push_back(r);
        endfunction

        function void check_reply(logic [fpba_pkg::STATUS_W-1:0] status,
                                  logic [fpba_pkg::IDX_FIELD_W-1:0] block,
                                  logic [fpba_pkg::SIZE_FIELD_W-1:0] left);
            reply_t want;
            if (due.size() == 0)
            begin
                $display("%0t: unexpected reply, status %0d block %0d left %0d",
                         $time, status, block, left);
                errors++;
                return;
            end
            want = due.pop_front();
            if (status !== want.status)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                errors++;
            end
            if (block !== want.block)
            begin
                $display("%0t: chosen_block expected %0d, got %0d", $time, want.block, block);
                errors++;
            end
            if (left !== want.left)
            begin
                $display("%0t: remaining_size expected %0d, got %0d", $time, want.left, left);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [0:0]                      cfg_index;
    logic [fpba_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [23:0]                     s_tdata;   // [3:0] block_index, [19:4] size_value
    logic [0:0]                      s_tuser;   // [0] req_type
    logic                            m_tvalid;
    logic                            m_tready;
    logic [23:0]                     m_tdata;   // [3:0] chosen_block, [19:4] remaining_size
    logic [1:0]                      m_tuser;   // [1:0] status

    allocation_ledger ledger = new();
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    int               hold_cycles = 0;
    bit [3:0]         policies_seen = '0;

    fit_policy_block_allocator_core #(
        .NUM_BLOCKS(TABLE_DEPTH),
        .SIZE_WIDTH(SIZE_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d replies outstanding", cycles, ledger.due.size());
        $display("testbench: errors");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            ledger.check_reply(m_tuser, m_tdata[3:0], m_tdata[19:4]);
    end

    initial
    begin : reply_side
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                m_tready <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = int'($urandom_range(1, 14));
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic [0:0] kind, input logic [fpba_pkg::IDX_FIELD_W-1:0] idx,
                         input logic [fpba_pkg::SIZE_FIELD_W-1:0] amount);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = int'($urandom_range(1, 14));
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, amount, idx};
        do
            @(posedge clk);
        while (!s_tready);
        ledger.note_request(kind, idx, amount);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (ledger.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_regs(input logic [fpba_pkg::CFG_DATA_W-1:0] policy_word,
                            input logic [fpba_pkg::CFG_DATA_W-1:0] count);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= fpba_pkg::REG_FIT_POLICY;
        cfg_data  <= policy_word;
        @(posedge clk);
        ledger.write_reg(fpba_pkg::REG_FIT_POLICY, policy_word);
        cfg_index <= fpba_pkg::REG_NUM_BLOCKS;
        cfg_data  <= count;
        @(posedge clk);
        ledger.write_reg(fpba_pkg::REG_NUM_BLOCKS, count);
        cfg_we <= 1'b0;
        policies_seen[policy_word[fpba_pkg::POLICY_W-1:0]] = 1'b1;
    endtask

    function automatic logic [fpba_pkg::SIZE_FIELD_W-1:0] random_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 15));
            3:       return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 65535));
            default: return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [fpba_pkg::SIZE_FIELD_W-1:0] random_request();
        logic [fpba_pkg::SIZE_FIELD_W-1:0] base;
        base = ledger.free_size[$urandom_range(0, TABLE_DEPTH - 1)];
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, 65535));
            2:       return base;
            3:       return (base == '1) ? base : base + 1'b1;
            default: return fpba_pkg::SIZE_FIELD_W'($urandom_range(0, base));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [fpba_pkg::CFG_DATA_W-1:0] count;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= fpba_pkg::REG_FIT_POLICY;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= fpba_pkg::REQ_LOAD;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: zero request fits, anything else refused
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd0);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd15, 16'd1);
        offer(fpba_pkg::REQ_LOAD, 4'd0, 16'hFFFF);
        offer(fpba_pkg::REQ_LOAD, 4'd15, 16'h8000);
        offer(fpba_pkg::REQ_LOAD, 4'd5, 16'd100);
        offer(fpba_pkg::REQ_LOAD, 4'd9, 16'd300);
        offer(fpba_pkg::REQ_LOAD, 4'd3, 16'd100);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd7, 16'd50);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_BEST), 5'd16);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd90);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'hFFFF);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_WORST), 5'd16);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'hFFCD);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd1);
        set_regs(5'd3, 5'd16);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd5);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST), 5'd0);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd0);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_WORST), 5'd31);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd0);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_BEST), 5'd1);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd0);
        offer(fpba_pkg::REQ_LOAD, 4'd12, 16'hAAAA);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'd1);
        set_regs(fpba_pkg::CFG_DATA_W'(fpba_pkg::FIT_FIRST), 5'd16);
        offer(fpba_pkg::REQ_ALLOCATE, 4'd0, 16'hAAAA);

        for (int p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 9))
                0:       count = 5'd0;
                1:       count = fpba_pkg::CFG_DATA_W'($urandom_range(17, 31));
                default: count = fpba_pkg::CFG_DATA_W'($urandom_range(1, 16));
            endcase
            set_regs({3'($urandom_range(0, 7)), 2'($urandom_range(0, 3))}, count);
            tx_idle_on = (p < 8);
            rx_idle_on = (p < 8);
            // refill the whole table, then mix loads and allocations
            for (int k = 0; k < TABLE_DEPTH; k++)
                offer(fpba_pkg::REQ_LOAD, fpba_pkg::IDX_FIELD_W'(k), random_size());
            for (int n = 0; n < 92; n++)
            begin
                if (p == 2 && n == 20)
                    hold_cycles = 300;
                if (p == 5 && n == 40)
                    wait_drained();
                if ($urandom_range(0, 9) < 4)
                    offer(fpba_pkg::REQ_LOAD,
                          fpba_pkg::IDX_FIELD_W'($urandom_range(0, 15)), random_size());
                else
                    offer(fpba_pkg::REQ_ALLOCATE,
                          fpba_pkg::IDX_FIELD_W'($urandom_range(0, 15)), random_request());
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("%0d items: %0d loads, %0d allocations granted, %0d refused",
                 ledger.loads + ledger.grants + ledger.refusals,
                 ledger.loads, ledger.grants, ledger.refusals);
        $display("fit policy codes written: %b; block counts from 0 to 31 with random settings",
                 policies_seen);
        if (ledger.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

@@ files.f @@
sv/fpba_pkg.sv
sv/fit_policy_block_allocator_core.sv
tb/testbench.sv
